### design/ecf_pkg.sv
package ecf_pkg;

    localparam int EASE_FRAC_BITS = 16;
    localparam int T_W            = EASE_FRAC_BITS + 1;
    localparam int Q_W            = EASE_FRAC_BITS + 4;
    localparam int QX_W           = Q_W + 1;
    localparam int E_W            = EASE_FRAC_BITS + 5;
    localparam int DIV_CNT_W      = $clog2(EASE_FRAC_BITS);

    localparam int FADE_W    = 16;
    localparam int FRAME_W   = 10;
    localparam int BRIGHT_W  = 7;
    localparam int ELAPSED_W = 16;
    localparam int CH_W      = 8;
    localparam int MOOD_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [T_W-1:0] EASE_ONE     = {1'b1, {EASE_FRAC_BITS{1'b0}}};
    localparam logic [T_W-1:0] EASE_ONE_M1  = EASE_ONE - T_W'(1);
    localparam logic [Q_W-1:0] EASE_TEN_ONE = Q_W'(10) << EASE_FRAC_BITS;

    localparam logic [FADE_W-1:0]   FADE_RESET   = 16'd3000;
    localparam logic [FRAME_W-1:0]  FRAME_RESET  = 10'd33;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;

    localparam int SCALE_PROD_W = CH_W + BRIGHT_W;
    localparam int SCALE_RCP_W  = 13;
    localparam int SCALE_FULL_W = SCALE_PROD_W + SCALE_RCP_W;
    localparam int SCALE_SHIFT  = 19;
    localparam int SCALE_Q_W    = 9;
    localparam logic [SCALE_RCP_W-1:0] SCALE_RECIP = 13'd5243;
    localparam logic [SCALE_Q_W-1:0]   SCALE_MAX   = 9'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_MS   = 2'd0,
        CFG_FRAME_MS  = 2'd1,
        CFG_BRIGHTNESS = 2'd2
    } cfg_idx_t;

    localparam logic KIND_MOOD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_MOOD = 1'b1;

    localparam logic [MOOD_W-1:0] MOOD_NEUTRAL  = 3'd0;
    localparam logic [MOOD_W-1:0] MOOD_LOW_NEG  = 3'd1;
    localparam logic [MOOD_W-1:0] MOOD_LOW_POS  = 3'd2;
    localparam logic [MOOD_W-1:0] MOOD_HIGH_NEG = 3'd3;
    localparam logic [MOOD_W-1:0] MOOD_HIGH_POS = 3'd4;
    localparam logic [MOOD_W-1:0] NUM_MOODS     = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    localparam color_t NEUTRAL_COLOR = '{r: 8'd86, g: 8'd72, b: 8'd50};

    typedef struct packed {
        logic       accept;
        logic       start;
        logic       prep;
        logic       div_step;
        logic       sqr;
        logic       cube;
        logic       ease;
        logic       blend;
        logic       scale_mul;
        logic       scale_div;
        logic       emit;
        logic [1:0] ch;
    } ecf_cmd_t;

    typedef struct packed {
        logic t_full;
    } ecf_status_t;

    function automatic color_t mood_color(input logic [MOOD_W-1:0] mood);
        color_t c;
        case (mood)
            MOOD_NEUTRAL:  c = NEUTRAL_COLOR;
            MOOD_LOW_NEG:  c = '{r: 8'd52, g: 8'd42, b: 8'd130};
            MOOD_LOW_POS:  c = '{r: 8'd42, g: 8'd128, b: 8'd150};
            MOOD_HIGH_NEG: c = '{r: 8'd150, g: 8'd42, b: 8'd0};
            MOOD_HIGH_POS: c = '{r: 8'd0, g: 8'd125, b: 8'd42};
            default:       c = NEUTRAL_COLOR;
        endcase
        return c;
    endfunction

endpackage

### design/eased_color_crossfader.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_kind, s_mood
// m_        out        m_valid / m_ready     m_is_frame, m_red_out, m_green_out, m_blue_out,
//                                            m_status
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is in flight at a time; a new item is taken once the previous one has moved
// into the output register. A mood request goes from idle straight to emit. A frame
// tick runs start, prep, the one-bit-per-cycle fade-fraction divider, square, cube,
// ease, blend and scale per channel, and emit; a complete fade skips the divider.
// Reset is synchronous; configuration writes are always taken.
// A stalled result holds in the output register while the next item is processed.
module eased_color_crossfader (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [ecf_pkg::MOOD_W-1:0]        s_mood,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_frame,
    output logic [ecf_pkg::CH_W-1:0]          m_red_out,
    output logic [ecf_pkg::CH_W-1:0]          m_green_out,
    output logic [ecf_pkg::CH_W-1:0]          m_blue_out,
    output logic                              m_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ecf_pkg::ecf_cmd_t    cmd;
    ecf_pkg::ecf_status_t status;

    assign cfg_ready = 1'b1;

    ecf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ecf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_kind      (s_kind),
        .s_mood      (s_mood),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_is_frame  (m_is_frame),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_status    (m_status)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while the previous item was still being processed.");

    a_mood_result_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_frame |-> m_red_out == '0 && m_green_out == '0 && m_blue_out == '0)
        else $error("Mood request result carries a nonzero color.");

    a_frame_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_frame |-> m_status == ecf_pkg::STATUS_OK)
        else $error("Frame result carries an error status.");
`endif

endmodule

### design/ecf_ctrl.sv
module ecf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ecf_pkg::ecf_status_t status,
    output ecf_pkg::ecf_cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_START = 11'b000_0000_0010,
        S_PREP  = 11'b000_0000_0100,
        S_DIV   = 11'b000_0000_1000,
        S_SQR   = 11'b000_0001_0000,
        S_CUBE  = 11'b000_0010_0000,
        S_EASE  = 11'b000_0100_0000,
        S_BLEND = 11'b000_1000_0000,
        S_SMUL  = 11'b001_0000_0000,
        S_SDIV  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } ecf_state_t;

    ecf_state_t                       state_reg, state_next;
    logic [ecf_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]                       ch_reg, ch_next;
    logic                             m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ch_next      = ch_reg;
        cmd          = '0;
        cmd.ch       = ch_reg;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_kind == ecf_pkg::KIND_TICK) ? S_START : S_EMIT;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (status.t_full) begin
                    state_next = S_SQR;
                end else begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == ecf_pkg::DIV_CNT_W'(ecf_pkg::EASE_FRAC_BITS - 1)) begin
                        state_next = S_SQR;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_SQR: begin
                cmd.sqr    = 1'b1;
                state_next = S_CUBE;
            end
            S_CUBE: begin
                cmd.cube   = 1'b1;
                state_next = S_EASE;
            end
            S_EASE: begin
                cmd.ease   = 1'b1;
                ch_next    = ecf_pkg::CH_RED;
                state_next = S_BLEND;
            end
            S_BLEND: begin
                cmd.blend = 1'b1;
                if (ch_reg == ecf_pkg::CH_BLUE) begin
                    ch_next    = ecf_pkg::CH_RED;
                    state_next = S_SMUL;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_SMUL: begin
                cmd.scale_mul = 1'b1;
                state_next    = S_SDIV;
            end
            S_SDIV: begin
                cmd.scale_div = 1'b1;
                if (ch_reg == ecf_pkg::CH_BLUE) begin
                    state_next = S_EMIT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_SMUL;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ch_reg      <= ecf_pkg::CH_RED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### design/ecf_datapath.sv
module ecf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ecf_pkg::ecf_cmd_t                 cmd,
    output ecf_pkg::ecf_status_t              status,
    input  logic                              s_kind,
    input  logic [ecf_pkg::MOOD_W-1:0]        s_mood,
    input  logic                              cfg_valid,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_is_frame,
    output logic [ecf_pkg::CH_W-1:0]          m_red_out,
    output logic [ecf_pkg::CH_W-1:0]          m_green_out,
    output logic [ecf_pkg::CH_W-1:0]          m_blue_out,
    output logic                              m_status
);

    localparam int F    = ecf_pkg::EASE_FRAC_BITS;
    localparam int T_W  = ecf_pkg::T_W;
    localparam int Q_W  = ecf_pkg::Q_W;
    localparam int QX_W = ecf_pkg::QX_W;
    localparam int E_W  = ecf_pkg::E_W;
    localparam int CH_W = ecf_pkg::CH_W;
    localparam int EL_W = ecf_pkg::ELAPSED_W;
    localparam int BL_W = CH_W + T_W;

    logic [ecf_pkg::FADE_W-1:0]   fade_ms_reg;
    logic [ecf_pkg::FRAME_W-1:0]  frame_ms_reg;
    logic [ecf_pkg::BRIGHT_W-1:0] bright_reg;

    ecf_pkg::color_t from_reg, goal_reg, shown_reg, req_reg;
    ecf_pkg::color_t shown_next;
    logic            pending_reg;
    logic [EL_W-1:0] elapsed_reg;

    logic [EL_W-1:0] rem_reg;
    logic [F-1:0]    quot_reg;
    logic            full_reg;
    logic [T_W-1:0]  t2_reg, t3_reg, e_reg;
    logic [Q_W-1:0]  q_reg;
    logic [ecf_pkg::SCALE_PROD_W-1:0] prod_reg;
    ecf_pkg::color_t res_reg;
    logic            res_frame_reg, res_status_reg;
    ecf_pkg::color_t out_color_reg;
    logic            out_frame_reg, out_status_reg;

    logic [T_W-1:0]      t_val;
    logic [EL_W:0]       rem_sh, fade_ext, div_diff;
    logic                div_ge;
    logic [2*T_W-1:0]    sqr_prod, cube_prod;
    logic [QX_W-1:0]     q_sum;
    logic [T_W+Q_W-1:0]  ease_prod;
    logic [E_W-1:0]      ease_sh;
    logic [CH_W-1:0]     from_ch, goal_ch, shown_ch, diff_ch, blend_val;
    logic                blend_up;
    logic [BL_W-1:0]     bl_prod, bl_ceil;
    logic [ecf_pkg::SCALE_FULL_W-1:0] scale_full;
    logic [ecf_pkg::SCALE_Q_W-1:0]    scale_q;
    logic [CH_W-1:0]     scale_sat;
    logic [EL_W:0]       elapsed_sum;
    logic                mood_ok;

    assign t_val = full_reg ? ecf_pkg::EASE_ONE : {1'b0, quot_reg};

    assign rem_sh   = {rem_reg, 1'b0};
    assign fade_ext = {1'b0, fade_ms_reg};
    assign div_ge   = (rem_sh >= fade_ext);
    assign div_diff = rem_sh - fade_ext;

    assign sqr_prod  = t_val * t_val;
    assign cube_prod = t2_reg * t_val;
    assign q_sum     = QX_W'(t2_reg) * QX_W'(6) + QX_W'(ecf_pkg::EASE_TEN_ONE)
                     - QX_W'(t_val) * QX_W'(15);
    assign ease_prod = t3_reg * q_reg;
    assign ease_sh   = ease_prod[T_W+Q_W-1:F];

    always_comb begin
        unique case (cmd.ch)
            ecf_pkg::CH_RED: begin
                from_ch  = from_reg.r;
                goal_ch  = goal_reg.r;
                shown_ch = shown_reg.r;
            end
            ecf_pkg::CH_GREEN: begin
                from_ch  = from_reg.g;
                goal_ch  = goal_reg.g;
                shown_ch = shown_reg.g;
            end
            default: begin
                from_ch  = from_reg.b;
                goal_ch  = goal_reg.b;
                shown_ch = shown_reg.b;
            end
        endcase
    end

    assign blend_up  = (goal_ch >= from_ch);
    assign diff_ch   = blend_up ? (goal_ch - from_ch) : (from_ch - goal_ch);
    assign bl_prod   = diff_ch * e_reg;
    assign bl_ceil   = bl_prod + BL_W'(ecf_pkg::EASE_ONE_M1);
    assign blend_val = blend_up ? (from_ch + bl_prod[F +: CH_W])
                                : (from_ch - bl_ceil[F +: CH_W]);

    always_comb begin
        shown_next = shown_reg;
        unique case (cmd.ch)
            ecf_pkg::CH_RED:   shown_next.r = blend_val;
            ecf_pkg::CH_GREEN: shown_next.g = blend_val;
            default:           shown_next.b = blend_val;
        endcase
    end

    assign scale_full = prod_reg * ecf_pkg::SCALE_RECIP;
    assign scale_q    = scale_full[ecf_pkg::SCALE_SHIFT +: ecf_pkg::SCALE_Q_W];
    assign scale_sat  = (scale_q > ecf_pkg::SCALE_MAX) ? {CH_W{1'b1}} : scale_q[CH_W-1:0];

    assign elapsed_sum = {1'b0, elapsed_reg} + (EL_W+1)'(frame_ms_reg);
    assign mood_ok     = (s_mood < ecf_pkg::NUM_MOODS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_ms_reg  <= ecf_pkg::FADE_RESET;
            frame_ms_reg <= ecf_pkg::FRAME_RESET;
            bright_reg   <= ecf_pkg::BRIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ecf_pkg::CFG_FADE_MS:    fade_ms_reg  <= cfg_data;
                ecf_pkg::CFG_FRAME_MS:   frame_ms_reg <= cfg_data[ecf_pkg::FRAME_W-1:0];
                ecf_pkg::CFG_BRIGHTNESS: bright_reg   <= cfg_data[ecf_pkg::BRIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_reg    <= ecf_pkg::NEUTRAL_COLOR;
            goal_reg    <= ecf_pkg::NEUTRAL_COLOR;
            shown_reg   <= ecf_pkg::NEUTRAL_COLOR;
            req_reg     <= ecf_pkg::NEUTRAL_COLOR;
            pending_reg <= 1'b0;
            elapsed_reg <= '0;
        end else begin
            if (cmd.accept && s_kind == ecf_pkg::KIND_MOOD && mood_ok) begin
                req_reg     <= ecf_pkg::mood_color(s_mood);
                pending_reg <= 1'b1;
            end
            if (cmd.start && pending_reg) begin
                from_reg    <= shown_reg;
                goal_reg    <= req_reg;
                elapsed_reg <= '0;
                pending_reg <= 1'b0;
            end
            if (cmd.ease) begin
                elapsed_reg <= elapsed_sum[EL_W] ? {EL_W{1'b1}} : elapsed_sum[EL_W-1:0];
            end
            if (cmd.blend) begin
                shown_reg <= shown_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_reg        <= '0;
            res_frame_reg  <= s_kind;
            res_status_reg <= (s_kind == ecf_pkg::KIND_MOOD && !mood_ok)
                              ? ecf_pkg::STATUS_BAD_MOOD : ecf_pkg::STATUS_OK;
        end
        if (cmd.prep) begin
            rem_reg  <= elapsed_reg;
            quot_reg <= '0;
            full_reg <= (fade_ms_reg == '0) || (elapsed_reg >= fade_ms_reg);
        end
        if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_diff[EL_W-1:0] : rem_sh[EL_W-1:0];
            quot_reg <= {quot_reg[F-2:0], div_ge};
        end
        if (cmd.sqr) begin
            t2_reg <= sqr_prod[F +: T_W];
        end
        if (cmd.cube) begin
            t3_reg <= cube_prod[F +: T_W];
            q_reg  <= q_sum[Q_W-1:0];
        end
        if (cmd.ease) begin
            e_reg <= (ease_sh > E_W'(ecf_pkg::EASE_ONE)) ? ecf_pkg::EASE_ONE
                                                          : ease_sh[T_W-1:0];
        end
        if (cmd.scale_mul) begin
            prod_reg <= shown_ch * bright_reg;
        end
        if (cmd.scale_div) begin
            unique case (cmd.ch)
                ecf_pkg::CH_RED:   res_reg.r <= scale_sat;
                ecf_pkg::CH_GREEN: res_reg.g <= scale_sat;
                default:           res_reg.b <= scale_sat;
            endcase
        end
        if (cmd.emit) begin
            out_color_reg  <= res_reg;
            out_frame_reg  <= res_frame_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign status.t_full = full_reg;

    assign m_is_frame  = out_frame_reg;
    assign m_red_out   = out_color_reg.r;
    assign m_green_out = out_color_reg.g;
    assign m_blue_out  = out_color_reg.b;
    assign m_status    = out_status_reg;

endmodule

### sim/ecf_frame_checker.sv
`timescale 1ns / 100ps

module ecf_frame_checker
    import ecf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_kind,
    input  logic [MOOD_W-1:0]     s_mood,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_is_frame,
    input  logic [CH_W-1:0]       m_red_out,
    input  logic [CH_W-1:0]       m_green_out,
    input  logic [CH_W-1:0]       m_blue_out,
    input  logic                  m_status,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    awaiting,
    output int                    results_checked
);

    typedef struct packed {
        logic            is_frame;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            status;
    } frame_out_t;

    frame_out_t expected_outputs[$];

    logic [FADE_W-1:0]    fade_len;
    logic [FRAME_W-1:0]   frame_step;
    logic [BRIGHT_W-1:0]  bright_pct;
    color_t               from_color;
    color_t               goal_color;
    color_t               shown_color;
    color_t               wanted_color;
    logic                 wanted_pending;
    logic [ELAPSED_W-1:0] fade_age;
    logic [MOOD_W-1:0]    active_mood;
    int                   error_tally;
    int                   result_tally;

    function automatic color_t palette_entry(input logic [MOOD_W-1:0] mood);
        case (mood)
            MOOD_LOW_NEG:  return color_t'{r: 8'd52, g: 8'd42, b: 8'd130};
            MOOD_LOW_POS:  return color_t'{r: 8'd42, g: 8'd128, b: 8'd150};
            MOOD_HIGH_NEG: return color_t'{r: 8'd150, g: 8'd42, b: 8'd0};
            MOOD_HIGH_POS: return color_t'{r: 8'd0, g: 8'd125, b: 8'd42};
            default:       return color_t'{r: 8'd86, g: 8'd72, b: 8'd50};
        endcase
    endfunction

    // Smootherstep weight of the elapsed fraction, both in Q1.16.
    function automatic bit [63:0] ease_weight(input logic [ELAPSED_W-1:0] el,
                                              input logic [FADE_W-1:0] len);
        bit [63:0] one;
        bit [63:0] t;
        bit [63:0] t2;
        bit [63:0] t3;
        bit [63:0] q;
        bit [63:0] e;
        one = 64'd1 << EASE_FRAC_BITS;
        if (len == '0) begin
            t = one;
        end else begin
            t = (64'(el) << EASE_FRAC_BITS) / 64'(len);
            if (t > one) begin
                t = one;
            end
        end
        t2 = (t * t) >> EASE_FRAC_BITS;
        t3 = (t2 * t) >> EASE_FRAC_BITS;
        q  = 64'd6 * t2 + 64'd10 * one - 64'd15 * t;
        e  = (t3 * q) >> EASE_FRAC_BITS;
        if (e > one) begin
            e = one;
        end
        return e;
    endfunction

    // A falling channel rounds its step up, so both directions floor the exact sum.
    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] from,
                                                    input logic [CH_W-1:0] goal,
                                                    input bit [63:0] e);
        bit [63:0] d;
        bit [63:0] one;
        one = 64'd1 << EASE_FRAC_BITS;
        if (goal >= from) begin
            d = 64'(goal) - 64'(from);
            return CH_W'(64'(from) + ((d * e) >> EASE_FRAC_BITS));
        end
        d = 64'(from) - 64'(goal);
        return CH_W'(64'(from) - ((d * e + one - 64'd1) >> EASE_FRAC_BITS));
    endfunction

    function automatic logic [CH_W-1:0] dim_channel(input logic [CH_W-1:0] c);
        bit [63:0] v;
        v = (64'(c) * 64'(bright_pct)) / 64'd100;
        return (v > 64'd255) ? 8'd255 : CH_W'(v);
    endfunction

    function automatic frame_out_t crossfade_step(input logic kind,
                                                  input logic [MOOD_W-1:0] mood);
        frame_out_t res;
        bit [63:0]  e;
        color_t     c;
        logic [ELAPSED_W:0] next_ms;
        res = '0;
        if (kind == KIND_MOOD) begin
            if (mood >= NUM_MOODS) begin
                res.status = STATUS_BAD_MOOD;
            end else begin
                active_mood    = mood;
                wanted_color   = palette_entry(mood);
                wanted_pending = 1'b1;
                res.status     = STATUS_OK;
            end
            return res;
        end
        if (wanted_pending) begin
            from_color     = shown_color;
            goal_color     = wanted_color;
            fade_age       = '0;
            wanted_pending = 1'b0;
        end
        e   = ease_weight(fade_age, fade_len);
        c.r = mix_channel(from_color.r, goal_color.r, e);
        c.g = mix_channel(from_color.g, goal_color.g, e);
        c.b = mix_channel(from_color.b, goal_color.b, e);
        shown_color = c;
        next_ms = (ELAPSED_W+1)'(fade_age) + (ELAPSED_W+1)'(frame_step);
        fade_age = next_ms[ELAPSED_W] ? '1 : next_ms[ELAPSED_W-1:0];
        res.is_frame = 1'b1;
        res.red      = dim_channel(c.r);
        res.green    = dim_channel(c.g);
        res.blue     = dim_channel(c.b);
        res.status   = STATUS_OK;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_tally++;
        end
    endtask

    always @(posedge aclk) begin
        frame_out_t want;
        if (!aresetn) begin
            fade_len       = FADE_RESET;
            frame_step     = FRAME_RESET;
            bright_pct     = BRIGHT_RESET;
            from_color     = palette_entry(MOOD_NEUTRAL);
            goal_color     = palette_entry(MOOD_NEUTRAL);
            shown_color    = palette_entry(MOOD_NEUTRAL);
            wanted_color   = palette_entry(MOOD_NEUTRAL);
            wanted_pending = 1'b0;
            fade_age       = '0;
            active_mood    = MOOD_NEUTRAL;
            error_tally    = 0;
            result_tally   = 0;
            expected_outputs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FADE_MS:    fade_len   = cfg_data[FADE_W-1:0];
                    CFG_FRAME_MS:   frame_step = cfg_data[FRAME_W-1:0];
                    CFG_BRIGHTNESS: bright_pct = cfg_data[BRIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    $error("Result with no item waiting: is_frame %0d rgb %0d,%0d,%0d status %0d",
                           m_is_frame, m_red_out, m_green_out, m_blue_out, m_status);
                    error_tally++;
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("is_frame", CH_W'(want.is_frame), CH_W'(m_is_frame));
                    check_field("red_out", want.red, m_red_out);
                    check_field("green_out", want.green, m_green_out);
                    check_field("blue_out", want.blue, m_blue_out);
                    check_field("status", CH_W'(want.status), CH_W'(m_status));
                    result_tally++;
                end
            end
            if (s_valid && s_ready) begin
                expected_outputs.push_back(crossfade_step(s_kind, s_mood));
            end
        end
        mismatches      <= error_tally;
        awaiting        <= expected_outputs.size();
        results_checked <= result_tally;
    end

endmodule

### sim/tb_eased_color_crossfader.sv
`timescale 1ns / 100ps

module tb_eased_color_crossfader;
    import ecf_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 950;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 64;
    localparam int TIMEOUT_NS      = 2_000_000;

    localparam logic [MOOD_W-1:0]    MOOD_TOP      = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_kind    = 1'b0;
    logic [MOOD_W-1:0]     s_mood    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_is_frame;
    logic [CH_W-1:0]       m_red_out;
    logic [CH_W-1:0]       m_green_out;
    logic [CH_W-1:0]       m_blue_out;
    logic                  m_status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int awaiting;
    int results_checked;

    int ticks_sent   = 0;
    int moods_sent   = 0;
    int random_sent  = 0;
    int burst_left   = 0;
    int cfg_writes   = 0;
    int holds_asked  = 0;
    int holds_served = 0;

    always #1 aclk = ~aclk;

    eased_color_crossfader dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_mood      (s_mood),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_frame  (m_is_frame),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    ecf_frame_checker u_frame_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_mood          (s_mood),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_frame      (m_is_frame),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_status        (m_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    task automatic send_item(input logic kind, input logic [MOOD_W-1:0] mood);
        @(negedge aclk);
        s_valid = 1'b1;
        s_kind  = kind;
        s_mood  = mood;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_TICK) begin
            ticks_sent++;
        end else begin
            moods_sent++;
        end
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid = 1'b0;
            s_kind  = 1'($urandom);
            s_mood  = MOOD_W'($urandom);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
            s_valid = 1'b0;
        end while (awaiting != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // Items go out in bursts; a new burst starts after a gap of random length.
    task automatic offer(input logic kind, input logic [MOOD_W-1:0] mood);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 19))
                0:       gap = 0;
                1, 2, 3: gap = $urandom_range(5, 45);
                default: gap = $urandom_range(1, 4);
            endcase
            idle_for(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(kind, mood);
        random_sent++;
    endtask

    initial begin
        ready_mode_t mode;
        int          seg_left;
        mode     = RDY_ALWAYS;
        seg_left = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != holds_asked) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                holds_served++;
            end else begin
                if (seg_left == 0) begin
                    mode     = ready_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    RDY_ALWAYS:   m_ready = 1'b1;
                    RDY_COIN:     m_ready = 1'($urandom);
                    RDY_SPARSE:   m_ready = ($urandom_range(0, 3) == 0);
                    default:      m_ready = ((seg_left % 5) != 0);
                endcase
            end
        end
    end

    initial begin
        int                  phase_no;
        int                  phase_len;
        int                  phase_base;
        int                  pick;
        int                  run_len;
        bit                  paused_once;
        logic [FADE_W-1:0]   fade_val;
        logic [FRAME_W-1:0]  frame_val;
        logic [BRIGHT_W-1:0] bright_val;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_item(KIND_TICK, MOOD_TOP);
        send_item(KIND_MOOD, NUM_MOODS);
        send_item(KIND_MOOD, MOOD_W'(NUM_MOODS + 3'd1));
        send_item(KIND_MOOD, MOOD_TOP);
        for (int mi = 0; mi < NUM_MOODS; mi++) begin
            send_item(KIND_MOOD, MOOD_W'(mi));
            send_item(KIND_TICK, MOOD_W'($urandom));
        end
        send_item(KIND_TICK, MOOD_NEUTRAL);

        wait_drained();
        cfg_write(CFG_FADE_MS, 16'd0);
        cfg_write(CFG_FRAME_MS, 16'd0);
        cfg_write(CFG_BRIGHTNESS, 16'd127);
        send_item(KIND_MOOD, MOOD_HIGH_NEG);
        send_item(KIND_TICK, MOOD_TOP);
        send_item(KIND_TICK, MOOD_NEUTRAL);

        wait_drained();
        cfg_write(CFG_SPARE_IDX, 16'hFFFF);
        cfg_write(CFG_FADE_MS, 16'hFFFF);
        cfg_write(CFG_FRAME_MS, 16'd1000);
        cfg_write(CFG_BRIGHTNESS, 16'd0);
        send_item(KIND_MOOD, MOOD_LOW_POS);
        send_item(KIND_TICK, MOOD_NEUTRAL);
        send_item(KIND_TICK, MOOD_TOP);

        phase_no    = 0;
        paused_once = 1'b0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            if (phase_no == 0) begin
                // A slow fade with long frames runs the elapsed time into saturation.
                cfg_write(CFG_FADE_MS, 16'hFFFF);
                cfg_write(CFG_FRAME_MS, 16'd1000);
                cfg_write(CFG_BRIGHTNESS, 16'(100));
                offer(KIND_MOOD, MOOD_HIGH_POS);
                repeat (80) offer(KIND_TICK, MOOD_W'($urandom));
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       fade_val = '0;
                        1:       fade_val = 16'd1;
                        2:       fade_val = '1;
                        3:       fade_val = 16'($urandom);
                        default: fade_val = 16'($urandom_range(1, 1500));
                    endcase
                    cfg_write(CFG_FADE_MS, fade_val);
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       frame_val = '0;
                        1:       frame_val = 10'd1;
                        2:       frame_val = 10'd1000;
                        3:       frame_val = '1;
                        default: frame_val = 10'($urandom_range(1, 200));
                    endcase
                    cfg_write(CFG_FRAME_MS, {6'($urandom), frame_val});
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 4))
                        0:       bright_val = '0;
                        1:       bright_val = 7'd100;
                        2:       bright_val = '1;
                        default: bright_val = 7'($urandom_range(0, 127));
                    endcase
                    cfg_write(CFG_BRIGHTNESS, {9'($urandom), bright_val});
                end
                if (phase_no == 1) begin
                    holds_asked++;
                end
                phase_len  = $urandom_range(30, 110);
                phase_base = random_sent;
                while (random_sent - phase_base < phase_len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        offer(KIND_MOOD, MOOD_W'($urandom_range(0, NUM_MOODS - 1)));
                        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                              : $urandom_range(1, 16);
                        repeat (run_len) offer(KIND_TICK, MOOD_W'($urandom));
                    end else if (pick < 80) begin
                        offer(KIND_MOOD, MOOD_W'($urandom_range(NUM_MOODS, MOOD_TOP)));
                    end else if (pick < 90) begin
                        offer(KIND_TICK, MOOD_W'($urandom));
                    end else begin
                        offer(KIND_MOOD, MOOD_W'($urandom_range(0, NUM_MOODS - 1)));
                        offer(KIND_MOOD, MOOD_W'($urandom));
                        repeat ($urandom_range(1, 6)) offer(KIND_TICK, MOOD_W'($urandom));
                    end
                    if ((phase_no >= 2 && !paused_once) || $urandom_range(0, 59) == 0) begin
                        wait_drained();
                        paused_once = 1'b1;
                    end
                end
            end
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d frame ticks, %0d mood requests) over %0d phases, %0d writes.",
                 ticks_sent + moods_sent, ticks_sent, moods_sent, phase_no, cfg_writes);
        $display("Checked %0d results; the receiver held off %0d time(s) for %0d cycles.",
                 results_checked, holds_served, HOLD_OFF_CYCLES);
        if (mismatches == 0 && awaiting == 0) begin
            $display("tb_eased_color_crossfader: PASS");
        end else begin
            $display("tb_eased_color_crossfader: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_eased_color_crossfader: FAIL");
        $finish;
    end

endmodule
